// File: design/range_kth_largest_select_core_macros.svh
// assertion macros shared by the range k-th largest select design
`ifndef RANGE_KTH_LARGEST_SELECT_CORE_MACROS_SVH
`define RANGE_KTH_LARGEST_SELECT_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define RKLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RKLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rkls_pkg.sv
// package: widths, codes and state type of the range k-th largest select design
package rkls_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int POS_W          = 6;
  localparam int RANK_W         = 7;
  localparam int IN_VALUE_W     = 32;
  localparam int OUT_VALUE_W    = 32;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_REVERSED = 2'd1,
    STAT_RANK     = 2'd2
  } status_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN
  } state_t;

endpackage

// File: design/rkls_store.sv
// element store: one write port, one registered read port, per-entry valid bits
module rkls_store #(
  parameter int DEPTH      = rkls_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = rkls_pkg::VALUE_BITS_DEF,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic signed [VALUE_BITS-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr,
  output logic signed [VALUE_BITS-1:0] rd_data
);
  import rkls_pkg::*;

  logic signed [VALUE_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]             vld_r;
  logic signed [VALUE_BITS-1:0] mem_q_r;
  logic                         vld_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      vld_q_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

// File: design/rkls_cell.sv
// insertion-sort cell: keeps the larger value, hands the smaller one on
module rkls_cell #(
  parameter int VALUE_BITS = rkls_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         in_vld,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         pass_vld,
  output logic signed [VALUE_BITS-1:0] pass_value,
  output logic signed [VALUE_BITS-1:0] held_value
);
  import rkls_pkg::*;

  logic                         held_vld_r;
  logic signed [VALUE_BITS-1:0] held_r;
  logic                         pass_vld_r;
  logic signed [VALUE_BITS-1:0] pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      held_vld_r <= 1'b0;
      pass_vld_r <= 1'b0;
    end else begin
      pass_vld_r <= in_vld && held_vld_r;
      if (in_vld) begin
        held_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      if (!held_vld_r || (in_value > held_r)) begin
        held_r <= in_value;
        pass_r <= held_r;
      end else begin
        pass_r <= in_value;
      end
    end
  end

  assign pass_vld   = pass_vld_r;
  assign pass_value = pass_r;
  assign held_value = held_r;

endmodule

// File: design/range_kth_largest_select_core.sv
// top level: range k-th largest select over a store and a sorting cell chain
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   input    | start / busy       | kind, position, new_value, range, rank_k
//   result   | out_valid (strobe) | kth_value, status
//
// a write gives no result; busy stays low
// a query with a reversed range or a bad rank gives its result the next cycle
// a good query streams range entries from the store port into the cell chain,
// one per cycle, then waits in the drain state for the chain to settle; the
// result is strobed in the cycle busy falls
// reset is synchronous active low; it clears control state and the store's
// valid bits, so every entry reads zero until written; the receiver cannot stall
module range_kth_largest_select_core #(
  parameter int DEPTH      = rkls_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = rkls_pkg::VALUE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      in_kind,
  input  logic [rkls_pkg::POS_W-1:0]                in_position,
  input  logic signed [rkls_pkg::IN_VALUE_W-1:0]    in_new_value,
  input  logic [rkls_pkg::POS_W-1:0]                in_range_low,
  input  logic [rkls_pkg::POS_W-1:0]                in_range_high,
  input  logic [rkls_pkg::RANK_W-1:0]               in_rank_k,
  output logic                                      out_valid,
  output logic signed [rkls_pkg::OUT_VALUE_W-1:0]   out_kth_value,
  output logic [1:0]                                out_status
);
  import rkls_pkg::*;
  `include "range_kth_largest_select_core_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > POS_W) ? AW : POS_W;       // position compare width
  localparam int LW = AW + 1;                          // range length width
  localparam int KW = (LW > RANK_W) ? LW : RANK_W;     // rank compare width
  localparam int DW = $clog2(DEPTH + 1);               // settle counter width

  // control state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [DW-1:0]     cnt_r, cnt_nxt;
  logic              feed_vld_r;

  // result registers
  logic                          out_valid_r, out_valid_nxt;
  logic signed [OUT_VALUE_W-1:0] out_value_r, out_value_nxt;
  status_t                       out_status_r, out_status_nxt;

  // input decode
  logic          accept;
  logic [CW-1:0] lo_ext, hi_ext, pos_ext;
  logic [AW-1:0] lo_a, hi_a;
  logic [LW-1:0] len;
  logic          pos_ok, reversed, rank_bad;

  // store and chain
  logic                         wr_en;
  logic                         rd_en;
  logic                         cell_clear;
  logic signed [VALUE_BITS-1:0] rd_data;
  logic                         link_vld   [DEPTH+1];
  logic signed [VALUE_BITS-1:0] link_value [DEPTH+1];
  logic signed [VALUE_BITS-1:0] held       [DEPTH];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // range bounds beyond the store saturate to its last slot; a write position beyond it is dropped
  assign lo_ext  = CW'(in_range_low);
  assign hi_ext  = CW'(in_range_high);
  assign pos_ext = CW'(in_position);
  assign lo_a    = AW'((lo_ext > CW'(DEPTH - 1)) ? CW'(DEPTH - 1) : lo_ext);
  assign hi_a    = AW'((hi_ext > CW'(DEPTH - 1)) ? CW'(DEPTH - 1) : hi_ext);
  assign pos_ok  = (pos_ext <= CW'(DEPTH - 1));

  assign reversed = (lo_a > hi_a);
  assign len      = LW'(hi_a) - LW'(lo_a) + LW'(1);
  assign rank_bad = (in_rank_k == '0) || (KW'(in_rank_k) > KW'(len));

  rkls_store #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_position)),
    .wr_data (VALUE_BITS'(in_new_value)),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  // read data lines up with its valid flag in the cycle after the address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_vld_r <= 1'b0;
    end else begin
      feed_vld_r <= rd_en;
    end
  end

  assign link_vld[0]   = feed_vld_r;
  assign link_value[0] = rd_data;

  // sorting chain: cell i ends up holding the (i+1)-th largest value fed in
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rkls_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clear      (cell_clear),
      .in_vld     (link_vld[i]),
      .in_value   (link_value[i]),
      .pass_vld   (link_vld[i+1]),
      .pass_value (link_value[i+1]),
      .held_value (held[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    hi_r         <= hi_nxt;
    k_r          <= k_nxt;
    cnt_r        <= cnt_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    hi_nxt         = hi_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    cell_clear     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (kind_t'(in_kind) == KIND_WRITE) begin
            wr_en = pos_ok;
          end else if (reversed) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = STAT_REVERSED;
          end else if (rank_bad) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = STAT_RANK;
          end else begin
            cell_clear = 1'b1;
            ptr_nxt    = lo_a;
            hi_nxt     = hi_a;
            k_nxt      = AW'(in_rank_k - RANK_W'(1));
            state_nxt  = ST_FEED;
          end
        end
      end
      ST_FEED: begin
        // one store read per cycle, low end of the range first
        rd_en = 1'b1;
        if (ptr_r == hi_r) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the last value to reach the far end of the chain
        if (cnt_r == DW'(DEPTH)) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = OUT_VALUE_W'(held[k_r]);
          out_status_nxt = STAT_OK;
          state_nxt      = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + DW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_kth_value = out_value_r;
  assign out_status    = out_status_r;

  `RKLS_ASSERT_NOW(a_err_zero, out_valid_r && (out_status_r != STAT_OK), out_value_r == '0, "error result carries a nonzero value")
  `RKLS_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == ST_IDLE, "result strobed while a query is still running")
  `RKLS_ASSERT_NOW(a_ptr_in_range, state_r == ST_FEED, ptr_r <= hi_r, "feed pointer ran past the range")
  `RKLS_ASSERT_NEXT(a_write_silent, accept && (in_kind == KIND_WRITE), !out_valid_r, "write transfer produced a result")
  `RKLS_ASSERT_NEXT(a_reversed_now, accept && (in_kind == KIND_QUERY) && reversed, out_valid_r && (out_status_r == STAT_REVERSED), "reversed range not reported at once")

endmodule
